// File: src/ffd_lattice_warp_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lattice warp block
// Small wrappers that keep the checks at the end of each module short.
// ---------------------------------------------------------------------------
`ifndef FFD_LATTICE_WARP_ASSERT_SVH
`define FFD_LATTICE_WARP_ASSERT_SVH

// Check that a condition implies another on the same edge.
`define FFD_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("%m: check failed");

// Check that a condition implies another on the next edge.
`define FFD_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("%m: check failed");

`endif

// File: src/ffd_pkg.sv
// ---------------------------------------------------------------------------
// Lattice warp package
// Shared sizes, opcodes and fixed-point helpers.
// ---------------------------------------------------------------------------
package ffd_pkg;
  localparam int MaxPerAxis = 4;
  localparam int FracBits   = 16;
  localparam int IdxW       = $clog2(MaxPerAxis);
  localparam int AddrW      = 3 * IdxW;
  localparam int LatDepth   = MaxPerAxis * MaxPerAxis * MaxPerAxis;
  localparam int CntW       = 3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_WARP  = 2'd2;

  localparam logic [1:0] CFG_COUNT_X = 2'd0;
  localparam logic [1:0] CFG_COUNT_Y = 2'd1;
  localparam logic [1:0] CFG_COUNT_Z = 2'd2;

  typedef logic signed [31:0] q_t;

  // Clamp a 34-bit sum to 32-bit signed.
  function automatic q_t sat34(input logic signed [33:0] v, output logic f);
    f = 1'b0;
    if (v > 34'sd2147483647) begin
      f = 1'b1; sat34 = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      f = 1'b1; sat34 = 32'sh80000000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

  // Round half up, floor shift, clamp a 64-bit product.
  function automatic q_t rnd_sat(input logic signed [63:0] p, output logic f);
    logic signed [64:0] r;
    logic signed [64:0] s;
    r = $signed({p[63], p}) + (65'sd1 <<< (FracBits - 1));
    s = r >>> FracBits;
    f = 1'b0;
    if (s > 65'sd2147483647) begin
      f = 1'b1; rnd_sat = 32'sh7fffffff;
    end else if (s < -65'sd2147483648) begin
      f = 1'b1; rnd_sat = 32'sh80000000;
    end else begin
      rnd_sat = s[31:0];
    end
  endfunction

  // Binomial coefficient C(n,i) for n below MaxPerAxis, built as a Pascal row.
  function automatic logic [7:0] binom(input logic [CntW-1:0] n, input logic [CntW-1:0] i);
    logic [7:0] row [MaxPerAxis];
    for (int c = 0; c < MaxPerAxis; c++) row[c] = (c == 0) ? 8'd1 : 8'd0;
    for (int r = 1; r < MaxPerAxis; r++) begin
      if (r <= int'(n)) begin
        for (int c = MaxPerAxis - 1; c >= 1; c--) row[c] = row[c] + row[c - 1];
      end
    end
    binom = row[i[IdxW-1:0]];
  endfunction
endpackage

// File: src/ffd_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module ffd_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/ffd_lattice_warp.sv
// ---------------------------------------------------------------------------
// Lattice warp top level
// Free-form deformation with trivariate Bernstein blending on one multiplier.
// ---------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)                      | tuser
// in_     | in  | index_i,j,k, value_x,y,z (102 bits, zero pad to 104) | opcode
// out_    | out | warped_x,y,z, saturated (97 bits, zero pad to 104)  | -
// cfg_    | in  | count_x/y/z by index                                | -
//
// Steps from accept to ready again: write stores the entry; add reads, adds
// and writes back; warp reads the corner, forms local coordinates, then per
// weight one set-up plus count-1 products, then per control point two weight
// products, a read wait, then x, y, z products. One 32x32 multiplier serves
// every product, so the work is serialised.
// Reset: counts return to 4; the lattice is undefined until written.
// Stalls: in_tready is low while a request is in work; a finished warp holds
// in its last state while the output register still holds an untaken result.
`include "ffd_lattice_warp_assert.svh"
module ffd_lattice_warp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // index_i, index_j, index_k, value_x, value_y, value_z, zero pad
  input  logic [1:0]   in_tuser,  // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata, // warped_x, warped_y, warped_z, saturated, zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [2:0]   cfg_data
);
  import ffd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // read wait
  localparam logic [3:0] S_ADD   = 4'd2;  // add displacement and write back
  localparam logic [3:0] S_ORG   = 4'd3;  // local coordinates
  localparam logic [3:0] S_BINIT = 4'd4;  // start one Bernstein weight
  localparam logic [3:0] S_BMUL  = 4'd5;  // one weight product
  localparam logic [3:0] S_PT    = 4'd6;  // point loop: weight products
  localparam logic [3:0] S_PX    = 4'd7;  // coordinate product and sum
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;  // read latency

  logic [3:0] st_r;
  logic [CntW-1:0] cx_r, cy_r, cz_r;
  logic [1:0] op_r;
  logic [AddrW-1:0] addr_r;
  q_t vx_r, vy_r, vz_r;
  q_t stu_r [3];
  q_t wt_r [3][MaxPerAxis];          // Bernstein weights per axis
  logic [1:0] ax_r;                  // axis during set-up
  logic [IdxW-1:0] bi_r, bm_r;        // weight index, product step
  logic [IdxW-1:0] i_r, j_r, k_r;
  logic [1:0] ph_r;                  // phase inside one control point
  q_t w_r, acc_r [3];
  logic sat_r;
  logic ovalid_r;
  logic [103:0] odata_r;

  // Lattice memories, one per coordinate.
  logic we;
  logic [AddrW-1:0] raddr;
  q_t wd [3], rd [3];
  for (genvar g = 0; g < 3; g++) begin : g_lat
    ffd_ram #(.Width(32), .Depth(LatDepth)) u_ram (
      .clk, .we, .waddr(addr_r), .wdata(wd[g]), .raddr, .rdata(rd[g])
    );
  end

  function automatic logic [CntW-1:0] eff(input logic [CntW-1:0] c);
    if (c < CntW'(2)) eff = CntW'(2);
    else if (c > CntW'(MaxPerAxis)) eff = CntW'(MaxPerAxis);
    else eff = c;
  endfunction

  logic [CntW-1:0] nx, ny, nz, ncur;
  assign nx = eff(cx_r);
  assign ny = eff(cy_r);
  assign nz = eff(cz_r);
  assign ncur = (ax_r == 2'd0) ? nx : (ax_r == 2'd1) ? ny : nz;

  // Shared multiplier operands.
  q_t ma, mb, mres;
  logic mf;
  logic signed [63:0] mprod;
  assign mprod = 64'(ma) * 64'(mb);
  always_comb mres = rnd_sat(mprod, mf);

  q_t om;                          // 1 - x for current axis
  logic omf;
  always_comb om = sat34((34'sd1 <<< FracBits) - 34'(stu_r[ax_r]), omf);

  logic [1:0] pc;                  // coordinate in point phase
  assign pc = ph_r - 2'd1;

  always_comb begin
    ma = w_r;
    mb = stu_r[ax_r];
    if (st_r == S_BMUL) begin
      ma = wt_r[ax_r][bi_r];
      mb = ({1'b0, bm_r} < {1'b0, bi_r}) ? stu_r[ax_r] : om;
    end else if (st_r == S_PT) begin
      ma = (ph_r == 2'd0) ? wt_r[0][i_r] : w_r;
      mb = (ph_r == 2'd0) ? wt_r[1][j_r] : wt_r[2][k_r];
    end else if (st_r == S_PX) begin
      ma = w_r;
      mb = rd[pc];
    end
  end

  // Read the request's entry (or the corner) while waiting, else the point loop.
  assign raddr = (st_r == S_RD) ? addr_r : {i_r, j_r, k_r};
  logic [AddrW-1:0] in_addr;
  assign in_addr = {in_tdata[1:0], in_tdata[3:2], in_tdata[5:4]};

  logic sf [3];
  q_t addv [3];
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      q_t v;
      v = (g == 0) ? vx_r : (g == 1) ? vy_r : vz_r;
      addv[g] = sat34(34'(rd[g]) + 34'(v), sf[g]);
      wd[g] = (op_r == OP_WRITE) ? v : addv[g];
    end
  end
  assign we = (st_r == S_ADD);

  logic [IdxW:0] bm_last;
  assign bm_last = IdxW'(1) + IdxW'(ncur - CntW'(2)) + 1'b0;

  q_t sumv;
  logic sumf;
  always_comb sumv = sat34(34'(acc_r[pc]) + 34'(mres), sumf);

  q_t dif [3];
  logic dff [3];
  always_comb begin
    dif[0] = sat34(34'(vx_r) - 34'(rd[0]), dff[0]);
    dif[1] = sat34(34'(vy_r) - 34'(rd[1]), dff[1]);
    dif[2] = sat34(34'(vz_r) - 34'(rd[2]), dff[2]);
  end

  assign in_tready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cx_r <= CntW'(4); cy_r <= CntW'(4); cz_r <= CntW'(4);
      ovalid_r <= 1'b0;
    end else begin
      // The user must take configuration only while idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT_X: cx_r <= cfg_data;
          CFG_COUNT_Y: cy_r <= cfg_data;
          CFG_COUNT_Z: cz_r <= cfg_data;
          default: ;
        endcase
      end
      // Drop the result once taken, unless a new one is loaded on the same edge.
      if (out_tvalid && out_tready && st_r != S_OUT) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tuser;
            vx_r <= in_tdata[37:6]; vy_r <= in_tdata[69:38]; vz_r <= in_tdata[101:70];
            sat_r <= 1'b0;
            if (in_tuser == OP_WRITE) begin
              addr_r <= in_addr; st_r <= S_ADD;
            end else if (in_tuser == OP_ADD) begin
              addr_r <= in_addr; st_r <= S_RD;
            end else if (in_tuser == OP_WARP) begin
              addr_r <= '0; st_r <= S_RD;
            end
          end
        end
        S_RD: st_r <= (op_r == OP_WARP) ? S_ORG : S_ADD;
        S_ADD: st_r <= S_IDLE;
        S_ORG: begin
          stu_r[0] <= dif[0]; stu_r[1] <= dif[1]; stu_r[2] <= dif[2];
          sat_r <= dff[0] | dff[1] | dff[2];
          ax_r <= 2'd0; bi_r <= '0;
          st_r <= S_BINIT;
        end
        S_BINIT: begin
          // Coefficient in fixed point, then (n-1) products.
          wt_r[ax_r][bi_r] <= q_t'({24'd0, binom(ncur - CntW'(1), CntW'(bi_r))}) <<< FracBits;
          sat_r <= sat_r | omf;
          bm_r <= '0;
          st_r <= S_BMUL;
        end
        S_BMUL: begin
          wt_r[ax_r][bi_r] <= mres;
          sat_r <= sat_r | mf;
          if ({1'b0, bm_r} == bm_last - 1'b1) begin
            if (CntW'(bi_r) == ncur - CntW'(1)) begin
              bi_r <= '0;
              if (ax_r == 2'd2) begin
                i_r <= '0; j_r <= '0; k_r <= '0; ph_r <= '0;
                acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
                st_r <= S_PT;
              end else begin
                ax_r <= ax_r + 2'd1; st_r <= S_BINIT;
              end
            end else begin
              bi_r <= bi_r + 1'b1; st_r <= S_BINIT;
            end
          end else begin
            bm_r <= bm_r + 1'b1;
          end
        end
        S_PT: begin
          w_r <= mres;
          sat_r <= sat_r | mf;
          if (ph_r == 2'd0) ph_r <= 2'd1;
          else begin
            st_r <= S_WAIT;
          end
        end
        S_WAIT: st_r <= S_PX;
        S_PX: begin
          acc_r[pc] <= sumv;
          sat_r <= sat_r | mf | sumf;
          if (ph_r == 2'd3) begin
            ph_r <= '0;
            st_r <= S_PT;
            if (CntW'(k_r) == nz - CntW'(1)) begin
              k_r <= '0;
              if (CntW'(j_r) == ny - CntW'(1)) begin
                j_r <= '0;
                if (CntW'(i_r) == nx - CntW'(1)) st_r <= S_OUT;
                else i_r <= i_r + 1'b1;
              end else j_r <= j_r + 1'b1;
            end else k_r <= k_r + 1'b1;
          end else ph_r <= ph_r + 2'd1;
        end
        S_OUT: begin
          // Hold until the output register is free or being emptied.
          if (!ovalid_r || out_tready) begin
            odata_r <= {7'd0, sat_r, acc_r[2], acc_r[1], acc_r[0]};
            ovalid_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  `FFD_ASSERT_IMP(a_busy, clk, rst_n, st_r != S_IDLE, !in_tready)
  `FFD_ASSERT_NXT(a_out, clk, rst_n, st_r == S_OUT, out_tvalid)
  `FFD_ASSERT_IMP(a_we, clk, rst_n, we, op_r == OP_WRITE || op_r == OP_ADD)
endmodule
